### hw/rtl/tkct_pkg.sv
// shared types and constants for the ttl keyed cache table
// record layout, opcodes, controller states and command/status bundles
// no dependencies
package tkct_pkg;

   localparam logic       OP_PUT         = 1'b0;
   localparam logic       OP_GET         = 1'b1;
   localparam logic       STS_OK         = 1'b0;
   localparam logic       STS_MISS       = 1'b1;
   localparam logic [30:0] TTL_DEFAULT_MS = 31'd300000;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] value;
      logic [63:0] stamp;
   } record_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_EVICT_INIT,
      ST_OLDEST,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_APPEND,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic find_en;
      logic oldest_en;
      logic move_read;
      logic move_write;
      logic append;
      logic update;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_get;
      logic scan_done;
      logic key_match;
      logic table_full;
   } sts_type;

endpackage

### hw/rtl/tkct_ctrl.sv
// controller state machine for the ttl keyed cache table
// sequences key search, eviction, table writes and the result transaction
// depends on tkct_pkg
module tkct_ctrl
   import tkct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_FIND;
         end
         ST_FIND: begin
            if (sts.key_match) begin
               state_in = sts.is_get ? ST_RESPOND : ST_UPDATE;
            end else if (sts.scan_done) begin
               if (sts.is_get)          state_in = ST_RESPOND;
               else if (sts.table_full) state_in = ST_EVICT_INIT;
               else                     state_in = ST_APPEND;
            end
         end
         ST_EVICT_INIT: state_in = ST_OLDEST;
         ST_OLDEST: begin
            if (sts.scan_done) state_in = ST_MOVE_RD;
         end
         ST_MOVE_RD:  state_in = ST_MOVE_WR;
         ST_MOVE_WR:  state_in = ST_APPEND;
         ST_APPEND:   state_in = ST_RESPOND;
         ST_UPDATE:   state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture    = accept;
            cmd.scan_start = accept;
         end
         ST_FIND: begin
            cmd.scan_step = 1'b1;
            cmd.find_en   = 1'b1;
         end
         ST_EVICT_INIT: cmd.scan_start = 1'b1;
         ST_OLDEST: begin
            cmd.scan_step = 1'b1;
            cmd.oldest_en = 1'b1;
         end
         ST_MOVE_RD:  cmd.move_read  = 1'b1;
         ST_MOVE_WR:  cmd.move_write = 1'b1;
         ST_APPEND:   cmd.append     = 1'b1;
         ST_UPDATE:   cmd.update     = 1'b1;
         ST_RESPOND:  cmd.rsp_load   = rsp_free;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)    rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/tkct_datapath.sv
// datapath for the ttl keyed cache table
// record memory, scan pointer, key and age compare, oldest tracking, result register
// depends on tkct_pkg
module tkct_datapath
   import tkct_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_opcode,
   input  logic [63:0] req_key_hash,
   input  logic [63:0] req_value_word,
   input  logic [63:0] req_now_ms,
   input  logic        csr_write,
   input  logic [30:0] csr_ttl_limit_ms,
   output logic        rsp_status,
   output logic [63:0] rsp_read_value,
   output logic [5:0]  rsp_entry_total
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   record_type mem [ENTRIES];
   record_type rdata_ff;
   record_type wdata;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] waddr;
   logic             we;

   logic        op_ff;
   logic [63:0] key_ff, val_ff, now_ff;
   logic [30:0] ttl_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] last_cnt;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             issue_ok;

   logic             match_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic [63:0]      match_val_ff;
   logic             fresh_ff;
   logic [IDX_W-1:0] oldest_idx_ff;
   logic [63:0]      oldest_stamp_ff;

   logic [63:0]      age;
   logic             fresh;
   logic             key_match;
   logic             hit;
   logic [CNT_W+5:0] total_ext;

   logic             status_ff;
   logic [63:0]      read_value_ff;
   logic [5:0]       entry_total_ff;

   assign issue_ok  = rd_ptr_ff < count_ff;
   assign last_cnt  = count_ff - 1'b1;
   assign key_match = cmp_vld_ff && (rdata_ff.key == key_ff);
   assign age       = now_ff - rdata_ff.stamp;
   assign fresh     = age <= {33'd0, ttl_ff};

   assign sts.is_get     = (op_ff == OP_GET);
   assign sts.scan_done  = !cmp_vld_ff && !issue_ok;
   assign sts.key_match  = key_match;
   assign sts.table_full = (count_ff == CNT_W'(ENTRIES));

   // scan pointer: issue one read a cycle, compare the read data in the next cycle
   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      cmp_ptr_in = cmp_ptr_ff;
      cmp_vld_in = 1'b0;
      if (cmd.scan_start) begin
         rd_ptr_in = '0;
      end else if (cmd.scan_step && issue_ok) begin
         rd_ptr_in  = rd_ptr_ff + 1'b1;
         cmp_ptr_in = rd_ptr_ff[IDX_W-1:0];
         cmp_vld_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append)          count_in = count_ff + 1'b1;
      else if (cmd.move_write) count_in = last_cnt;
   end

   assign rd_addr = cmd.move_read ? last_cnt[IDX_W-1:0] : rd_ptr_ff[IDX_W-1:0];
   assign we      = cmd.update || cmd.move_write || cmd.append;

   always_comb begin
      if (cmd.update)          waddr = match_idx_ff;
      else if (cmd.move_write) waddr = oldest_idx_ff;
      else                     waddr = count_ff[IDX_W-1:0];
   end

   always_comb begin
      if (cmd.move_write) begin
         wdata = rdata_ff;
      end else begin
         wdata.key   = key_ff;
         wdata.value = val_ff;
         wdata.stamp = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_ptr_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         match_ff   <= 1'b0;
         ttl_ff     <= TTL_DEFAULT_MS;
      end else begin
         count_ff   <= count_in;
         rd_ptr_ff  <= rd_ptr_in;
         cmp_vld_ff <= cmp_vld_in;
         if (cmd.capture) begin
            match_ff <= 1'b0;
         end else if (cmd.find_en && key_match) begin
            match_ff <= 1'b1;
         end
         if (csr_write) begin
            ttl_ff <= (csr_ttl_limit_ms == '0) ? TTL_DEFAULT_MS : csr_ttl_limit_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_ptr_ff <= cmp_ptr_in;
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         key_ff <= req_key_hash;
         val_ff <= req_value_word;
         now_ff <= req_now_ms;
      end
      if (cmd.find_en && key_match) begin
         match_idx_ff <= cmp_ptr_ff;
         match_val_ff <= rdata_ff.value;
         fresh_ff     <= fresh;
      end
      if (cmd.oldest_en && cmp_vld_ff) begin
         if ((cmp_ptr_ff == '0) || (rdata_ff.stamp < oldest_stamp_ff)) begin
            oldest_idx_ff   <= cmp_ptr_ff;
            oldest_stamp_ff <= rdata_ff.stamp;
         end
      end
   end

   // result register
   assign hit       = (op_ff == OP_GET) && match_ff && fresh_ff;
   assign total_ext = {6'd0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff      <= ((op_ff == OP_GET) && !hit) ? STS_MISS : STS_OK;
         read_value_ff  <= hit ? match_val_ff : 64'd0;
         entry_total_ff <= total_ext[5:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_entry_total = entry_total_ff;

endmodule

### hw/rtl/ttl_keyed_cache_table.sv
// top level of the ttl keyed cache table: fully associative key/value store
// with oldest-write eviction and an age check on reads
// depends on tkct_pkg, tkct_ctrl, tkct_datapath
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    opcode, key_hash, value_word, now_ms
//   rsp      out        rsp_valid/rsp_ready    status, read_value, entry_total
//   csr      in         csr_valid/csr_ready    ttl_limit_ms (always ready)
//
// one transaction at a time; the record memory is scanned one entry a cycle
// a get or put stops its scan at a matching key; a miss scans every stored record
// put into a full table: two full scans, then a move of the last record
// into the oldest slot before the new record is appended
// synchronous reset empties the table and restores the default ttl
// a held-off rsp transaction blocks only the next result, not the next request
module ttl_keyed_cache_table
   import tkct_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [63:0] req_key_hash,
   input  logic [63:0] req_value_word,
   input  logic [63:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [63:0] rsp_read_value,
   output logic [5:0]  rsp_entry_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_ttl_limit_ms
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tkct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tkct_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_key_hash     (req_key_hash),
      .req_value_word   (req_value_word),
      .req_now_ms       (req_now_ms),
      .csr_write        (csr_valid && csr_ready),
      .csr_ttl_limit_ms (csr_ttl_limit_ms),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_entry_total  (rsp_entry_total)
   );

endmodule
